@@ rtl/aac_pkg.sv @@
// Shared types, fixed-point constants and rounding helper for the
// single-axis attitude controller. No dependencies.
package aac_pkg;

  // Q.20 and Q.12 angle wrap bounds
  localparam logic signed [25:0] PI_Q20     = 26'sd3294199;
  localparam logic signed [25:0] TWO_PI_Q20 = 26'sd6588397;
  localparam logic signed [25:0] ONE_RAD_Q20 = 26'sd1048576;
  localparam logic signed [16:0] PI_Q12     = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;

  // quotient bits of the blend divider (blend step never exceeds one radian in Q.20)
  localparam int QUO_W = 21;

  // configuration register indexes
  localparam logic [2:0] REG_TORQUE_LIMIT = 3'd0;
  localparam logic [2:0] REG_DETUMBLE_GAIN = 3'd1;
  localparam logic [2:0] REG_DAMPING_GAIN = 3'd2;
  localparam logic [2:0] REG_SLEW_GAIN = 3'd3;
  localparam logic [2:0] REG_POINTING_BAND = 3'd4;
  localparam logic [2:0] REG_STICTION_PUSH = 3'd5;
  localparam logic [2:0] REG_TARGET_ANGLE = 3'd6;
  localparam logic [2:0] REG_TARGET_GIVEN = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INTEG, ST_ADD, ST_HWRAP, ST_ERR, ST_EWRAP, ST_DECIDE,
    ST_BMUL, ST_BDIV, ST_BWAIT, ST_FWRAP, ST_H12, ST_CTL, ST_PWRAP,
    ST_PBAND, ST_RCMD, ST_DMUL, ST_TSUM, ST_TRND, ST_OUT
  } aac_state_t;

  // round x / 2^sh to nearest, ties away from zero
  function automatic logic signed [47:0] rnd_shr(input logic signed [47:0] x,
                                                 input logic [3:0] sh);
    logic [47:0] mag;
    logic [47:0] q;
    mag = x[47] ? 48'(-x) : 48'(x);
    q   = (mag + (48'd1 << (sh - 4'd1))) >> sh;
    return x[47] ? -$signed(q) : $signed(q);
  endfunction

endpackage

@@ rtl/single_axis_attitude_controller_unit.sv @@
// Single-axis attitude controller top level: sequencer, shared multiplier,
// datapath registers. Depends on aac_pkg and aac_div.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------
//  in_     | slave     | tdata: rate, dt, fix_angle; tuser: mode, fix_valid
//  out_    | master    | tdata: torque, heading_est; tuser: clipped, in_band
//  cfg_    | write     | index 0..7, data up to 16 bits
//
// From acceptance to the next acceptance, one transaction runs a few steps of the
// shared 25x18 multiplier, the wrap loops (one 2*pi step per cycle) and, when the
// compass blends, the serial divider (start, 21 quotient bits, finish).
// in_tready is high only in idle; a finished result sits in the output
// register, so the next transaction may be taken while it waits. The last step
// stalls only while that register still holds an unaccepted result.
// Synchronous active-low reset; all filter and pointing state clears to zero.
module single_axis_attitude_controller_unit
  import aac_pkg::*;
#(
  parameter int DETUMBLE_DEADBAND = 20,
  parameter int STUCK_RATE        = 8,
  parameter int FILTER_TAU        = 131072,
  parameter int SLEW_LIMIT        = 410
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // rate[15:0], dt[31:16], fix_angle[46:32], pad
  input  logic [1:0]  in_tuser,   // mode[0], fix_valid[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // torque[15:0], heading_est[30:16], pad
  output logic [1:0]  out_tuser,  // clipped[0], in_band[1]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DW = $clog2(FILTER_TAU + 65536);
  localparam int NW = DW + QUO_W;

  // config registers
  logic [14:0]        tl_r;
  logic [15:0]        dg_r, mg_r, sg_r;
  logic [13:0]        band_cfg_r;
  logic [14:0]        push_r;
  logic signed [14:0] tgt_cfg_r;
  logic               tg_r;

  // captured transaction
  logic               mode_r, fix_r;
  logic signed [15:0] rate_r;
  logic [15:0]        dt_r;
  logic signed [14:0] fang_r;

  // state and working registers
  aac_state_t         st_r, st_nxt;
  logic signed [23:0] acc_r, acc_nxt;
  logic               seen_r, seen_nxt, wasp_r, wasp_nxt;
  logic signed [14:0] held_r, held_nxt, h12_r, h12_nxt;
  logic signed [25:0] h_r, h_nxt, e_r, e_nxt;
  logic signed [42:0] p_r, p_nxt;
  logic signed [16:0] err_r, err_nxt;
  logic signed [17:0] d_r, d_nxt;
  logic signed [23:0] t_r, t_nxt;
  logic               band_r, band_nxt;

  // output register
  logic               ov_r, ov_nxt;
  logic signed [15:0] otq_r, otq_nxt;
  logic signed [14:0] ohd_r, ohd_nxt;
  logic               oclp_r, oclp_nxt, oband_r, oband_nxt;

  // shared multiplier
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] mul_p;

  logic               div_start, div_done;
  logic [QUO_W-1:0]   div_q;
  logic [NW-1:0]      div_num;
  logic [DW-1:0]      div_den;

  logic               in_acc, out_free;
  logic [16:0]        rate_abs;
  logic [16:0]        err_abs;
  logic [25:0]        e_abs;
  logic signed [14:0] tgt;
  logic signed [25:0] rcmd;
  logic signed [23:0] lim;
  logic [42:0]        p_abs;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !ov_r || out_tready;
  assign rate_abs = rate_r[15] ? 17'(-rate_r) : 17'(rate_r);
  assign err_abs  = err_r[16] ? 17'(-err_r) : 17'(err_r);
  assign e_abs    = e_r[25] ? 26'(-e_r) : 26'(e_r);
  assign p_abs    = p_r[42] ? 43'(-p_r) : 43'(p_r);
  assign lim      = 24'(tl_r);
  assign mul_p    = 43'(mul_a * mul_b);
  assign div_den  = DW'(FILTER_TAU) + DW'(dt_r);
  assign div_num  = NW'(p_abs + 43'(div_den >> 1));

  // target: commanded, or heading held on pointing entry (captured this cycle on entry)
  always_comb begin
    if (tg_r) begin
      tgt = tgt_cfg_r;
    end else if (!wasp_r) begin
      tgt = h12_r;
    end else begin
      tgt = held_r;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (in_acc) st_nxt = ST_INTEG;
      ST_INTEG:  st_nxt = ST_ADD;
      ST_ADD:    st_nxt = ST_HWRAP;
      ST_HWRAP:  if (h_r <= PI_Q20 && h_r >= -PI_Q20) st_nxt = fix_r ? ST_ERR : ST_H12;
      ST_ERR:    st_nxt = ST_EWRAP;
      ST_EWRAP:  if (e_r <= PI_Q20 && e_r >= -PI_Q20) st_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (!seen_r || $signed(e_abs) > ONE_RAD_Q20 || dt_r == '0) st_nxt = ST_FWRAP;
        else st_nxt = ST_BMUL;
      end
      ST_BMUL:   st_nxt = ST_BDIV;
      ST_BDIV:   st_nxt = ST_BWAIT;
      ST_BWAIT:  if (div_done) st_nxt = ST_FWRAP;
      ST_FWRAP:  if (h_r <= PI_Q20 && h_r >= -PI_Q20) st_nxt = ST_H12;
      ST_H12:    st_nxt = ST_CTL;
      ST_CTL: begin
        if (!mode_r) st_nxt = (rate_abs < 17'(DETUMBLE_DEADBAND)) ? ST_OUT : ST_TRND;
        else st_nxt = ST_PWRAP;
      end
      ST_PWRAP:  if (err_r <= PI_Q12 && err_r >= -PI_Q12) st_nxt = ST_PBAND;
      ST_PBAND:  st_nxt = (err_abs < 17'(band_cfg_r)) ? ST_TRND : ST_RCMD;
      ST_RCMD:   st_nxt = ST_DMUL;
      ST_DMUL:   st_nxt = ST_TSUM;
      ST_TSUM:   st_nxt = ST_OUT;
      ST_TRND:   st_nxt = ST_OUT;
      ST_OUT:    if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider start, multiplier operands
  always_comb begin
    in_tready = (st_r == ST_IDLE);
    div_start = (st_r == ST_BDIV);
    mul_a     = 25'(rate_r);
    mul_b     = 18'(dt_r);
    unique case (st_r)
      ST_BMUL:  begin mul_a = 25'(e_r);   mul_b = 18'(dt_r); end
      ST_CTL:   begin mul_a = 25'(rate_r); mul_b = 18'(dg_r); end
      ST_PBAND: begin
        if (err_abs < 17'(band_cfg_r)) begin
          mul_a = 25'(rate_r); mul_b = 18'(mg_r);
        end else begin
          mul_a = 25'(err_r);  mul_b = 18'(sg_r);
        end
      end
      ST_DMUL:  begin mul_a = 25'(d_r);   mul_b = 18'(mg_r); end
      default:  begin mul_a = 25'(rate_r); mul_b = 18'(dt_r); end
    endcase
  end

  // datapath
  always_comb begin
    acc_nxt  = acc_r;   seen_nxt = seen_r;  wasp_nxt = wasp_r;
    held_nxt = held_r;  h12_nxt  = h12_r;   h_nxt    = h_r;
    e_nxt    = e_r;     p_nxt    = p_r;     err_nxt  = err_r;
    d_nxt    = d_r;     t_nxt    = t_r;     band_nxt = band_r;
    ov_nxt   = ov_r;    otq_nxt  = otq_r;   ohd_nxt  = ohd_r;
    oclp_nxt = oclp_r;  oband_nxt = oband_r;
    rcmd     = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      ST_INTEG:  p_nxt = mul_p;
      ST_ADD:    h_nxt = 26'(acc_r) + 26'(rnd_shr(48'(p_r), 4'd8));
      ST_HWRAP, ST_FWRAP: begin
        if (h_r > PI_Q20) h_nxt = h_r - TWO_PI_Q20;
        else if (h_r < -PI_Q20) h_nxt = h_r + TWO_PI_Q20;
      end
      ST_ERR:    e_nxt = (26'(fang_r) <<< 8) - h_r;
      ST_EWRAP: begin
        if (e_r > PI_Q20) e_nxt = e_r - TWO_PI_Q20;
        else if (e_r < -PI_Q20) e_nxt = e_r + TWO_PI_Q20;
      end
      ST_DECIDE: begin
        if (!seen_r || $signed(e_abs) > ONE_RAD_Q20) begin
          h_nxt    = h_r + e_r;
          seen_nxt = 1'b1;
        end
      end
      ST_BMUL:   p_nxt = mul_p;
      ST_BWAIT: begin
        if (div_done) h_nxt = e_r[25] ? h_r - 26'(div_q) : h_r + 26'(div_q);
      end
      ST_H12: begin
        acc_nxt = h_r[23:0];
        h12_nxt = 15'(rnd_shr(48'(h_r), 4'd8));
      end
      ST_CTL: begin
        band_nxt = 1'b0;
        if (!mode_r) begin
          t_nxt = '0;
          p_nxt = mul_p;
        end else begin
          if (!wasp_r && !tg_r) held_nxt = h12_r;
          err_nxt = 17'(h12_r) - 17'(tgt);
        end
      end
      ST_PWRAP: begin
        if (err_r > PI_Q12) err_nxt = err_r - TWO_PI_Q12;
        else if (err_r < -PI_Q12) err_nxt = err_r + TWO_PI_Q12;
      end
      ST_PBAND: begin
        p_nxt    = mul_p;
        band_nxt = (err_abs < 17'(band_cfg_r));
      end
      ST_RCMD: begin
        rcmd = -26'(rnd_shr(48'(p_r), 4'd12));
        if (rcmd > 26'(SLEW_LIMIT)) rcmd = 26'(SLEW_LIMIT);
        else if (rcmd < -26'(SLEW_LIMIT)) rcmd = -26'(SLEW_LIMIT);
        d_nxt = 18'(rate_r) - 18'(rcmd);
      end
      ST_DMUL:   p_nxt = mul_p;
      ST_TSUM: begin
        t_nxt = 24'(rnd_shr(48'(p_r), 4'd12));
        if (rate_abs < 17'(STUCK_RATE)) begin
          t_nxt = (err_r > 0) ? t_nxt + 24'(push_r) : t_nxt - 24'(push_r);
        end
      end
      ST_TRND:   t_nxt = 24'(rnd_shr(48'(p_r), 4'd12));
      ST_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ohd_nxt   = h12_r;
          oband_nxt = band_r;
          wasp_nxt  = mode_r;
          if (t_r > lim) begin
            otq_nxt = 16'(lim);  oclp_nxt = 1'b1;
          end else if (t_r < -lim) begin
            otq_nxt = 16'(-lim); oclp_nxt = 1'b1;
          end else begin
            otq_nxt = 16'(t_r);  oclp_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      acc_r      <= '0;
      seen_r     <= 1'b0;
      wasp_r     <= 1'b0;
      held_r     <= '0;
      ov_r       <= 1'b0;
      tl_r       <= 15'd32767;
      dg_r       <= 16'd4096;
      mg_r       <= 16'd4096;
      sg_r       <= 16'd4096;
      band_cfg_r <= '0;
      push_r     <= '0;
      tgt_cfg_r  <= '0;
      tg_r       <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      acc_r  <= acc_nxt;
      seen_r <= seen_nxt;
      wasp_r <= wasp_nxt;
      held_r <= held_nxt;
      ov_r   <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TORQUE_LIMIT:  tl_r       <= cfg_data[14:0];
          REG_DETUMBLE_GAIN: dg_r       <= cfg_data;
          REG_DAMPING_GAIN:  mg_r       <= cfg_data;
          REG_SLEW_GAIN:     sg_r       <= cfg_data;
          REG_POINTING_BAND: band_cfg_r <= cfg_data[13:0];
          REG_STICTION_PUSH: push_r     <= cfg_data[14:0];
          REG_TARGET_ANGLE:  tgt_cfg_r  <= cfg_data[14:0];
          REG_TARGET_GIVEN:  tg_r       <= cfg_data[0];
          default: ;
        endcase
      end
    end
    if (in_acc) begin
      mode_r <= in_tuser[0];
      fix_r  <= in_tuser[1];
      rate_r <= in_tdata[15:0];
      dt_r   <= in_tdata[31:16];
      fang_r <= in_tdata[46:32];
    end
    h12_r   <= h12_nxt;
    h_r     <= h_nxt;
    e_r     <= e_nxt;
    p_r     <= p_nxt;
    err_r   <= err_nxt;
    d_r     <= d_nxt;
    t_r     <= t_nxt;
    band_r  <= band_nxt;
    otq_r   <= otq_nxt;
    ohd_r   <= ohd_nxt;
    oclp_r  <= oclp_nxt;
    oband_r <= oband_nxt;
  end

  aac_div #(.DW(DW), .QW(QUO_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, ohd_r, otq_r};
  assign out_tuser  = {oband_r, oclp_r};

endmodule

@@ rtl/aac_div.sv @@
// Bit-serial restoring divider for the compass blend step.
// Depends on nothing; one quotient bit per cycle.
module aac_div #(
  parameter int DW = 18,
  parameter int QW = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DW+QW-1:0]     num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic [QW-1:0]        quo
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] sh_r, sh_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [DW+1:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {1'b0, rem_r, sh_r[QW-1]} - {2'b00, den};
    if (start) begin
      rem_nxt = num[DW+QW-1:QW];
      sh_nxt  = num[QW-1:0];
      cnt_nxt = CW'(QW);
      quo_nxt = '0;
    end else if (cnt_r != '0) begin
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW-1:0];
      end else begin
        rem_nxt = {rem_r[DW-2:0], sh_r[QW-1]};
      end
      quo_nxt  = {quo_r[QW-2:0], ~trial[DW+1]};
      sh_nxt   = {sh_r[QW-2:0], 1'b0};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
